[rtl/pes_pkg.sv]
// Package for the periodic event scheduler: field widths, operation and
// status codes, item and slot structs, controller/datapath command types.
// No dependencies.
package pes_pkg;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned HANDLE_W = 16;
	localparam int unsigned PERIOD_W = 32;
	localparam int unsigned TIME_W   = 48;
	localparam int unsigned STAMP_W  = 32;
	localparam int unsigned STATUS_W = 3;

	// operation codes
	localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
	localparam logic [OP_W-1:0] OP_REQUEST = 2'd2;
	localparam logic [OP_W-1:0] OP_SPARE   = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NONE   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd4;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [HANDLE_W-1:0] handle;
		logic [PERIOD_W-1:0] period_ms;
		logic [TIME_W-1:0]   start_time;
		logic [TIME_W-1:0]   now_time;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] fired_handle;
		logic [TIME_W-1:0]   next_due;
	} out_item_t;

	// one table entry as held in the slot memory
	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [PERIOD_W-1:0] period;
		logic [TIME_W-1:0]   due;
		logic [STAMP_W-1:0]  stamp;
	} slot_t;

	// controller to datapath
	typedef struct packed {
		logic start;  // item accepted: latch it, clear scan results
		logic rd_en;  // read one slot this cycle
		logic exec;   // apply the operation and load the result
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free; // result register can take a new item
	} dp_stat_t;

endpackage

[rtl/pes_if.sv]
// Valid/ready channel interfaces for the scheduler's input and result items.
// Depends on pes_pkg.
interface pes_in_if import pes_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface pes_out_if import pes_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

[rtl/pes_ctrl.sv]
// Controller of the scheduler: sequences accept, slot scan, drain and
// execute. Depends on pes_pkg.
module pes_ctrl import pes_pkg::*; #(
	parameter int unsigned SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  dp_stat_t                   stat,
	output ctl_cmd_t                   cmd,
	output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr
);

	localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_LAST = 4'b0100,
		S_EXEC = 4'b1000
	} state_t;

	state_t        state_q, state_d;
	logic [AW-1:0] cnt_q;
	logic          cnt_last;

	assign cnt_last  = (cnt_q == AW'(SLOTS - 1));
	assign in_ready  = (state_q == S_IDLE);
	assign rd_addr   = cnt_q;
	assign cmd.start = in_valid && in_ready;
	assign cmd.rd_en = (state_q == S_SCAN);
	assign cmd.exec  = (state_q == S_EXEC) && stat.out_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (cnt_last) state_d = S_LAST;
			end
			S_LAST: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				cnt_q <= '0;
			end else if (cmd.rd_en && !cnt_last) begin
				cnt_q <= cnt_q + AW'(1);
			end
		end
	end

endmodule

[rtl/pes_dpath.sv]
// Datapath of the scheduler: slot memory, valid bits, scan trackers,
// execute logic, stamp counter and result register. Depends on pes_pkg.
module pes_dpath import pes_pkg::*; #(
	parameter int unsigned SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ctl_cmd_t                   cmd,
	input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
	output dp_stat_t                   stat,
	input  in_item_t                   in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output out_item_t                  out_item
);

	localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// slot table
	slot_t              mem [SLOTS];
	logic [SLOTS-1:0]   valid_q;

	// latched item
	in_item_t           item_q;

	// read stage
	slot_t              rd_s1;
	logic [AW-1:0]      idx_s1;
	logic               vld_s1;
	logic               cmp_s1;

	// scan results
	logic               match_found_q, free_found_q, best_found_q;
	logic [AW-1:0]      match_idx_q, free_idx_q, best_idx_q;
	slot_t              best_q;
	logic [TIME_W-1:0]  second_due_q;

	logic [STAMP_W-1:0] stamp_q;
	logic               out_valid_q;
	out_item_t          out_item_q;

	// execute outputs
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	slot_t              mem_wdata;
	logic               valid_set, valid_clr, stamp_inc;
	out_item_t          res_d;

	logic               key_lt;
	logic [TIME_W:0]    due_sum;
	logic [TIME_W-1:0]  due_sat, due_new, best_due_or_max;

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_item      = out_item_q;

	// slot memory, one write and one read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (cmd.rd_en) begin
			rd_s1  <= mem[rd_addr];
			idx_s1 <= rd_addr;
			vld_s1 <= valid_q[rd_addr];
		end
	end

	// earlier key: due first, stamp breaks ties
	assign key_lt = !best_found_q || (rd_s1.due < best_q.due) ||
		((rd_s1.due == best_q.due) && (rd_s1.stamp < best_q.stamp));

	// scan trackers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_s1        <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			best_found_q  <= 1'b0;
		end else begin
			cmp_s1 <= cmd.rd_en;
			if (cmd.start) begin
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
				best_found_q  <= 1'b0;
				second_due_q  <= TIME_MAX;
				item_q        <= in_item;
			end else if (cmp_s1) begin
				if (!vld_s1 && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
				if (vld_s1 && !match_found_q && (rd_s1.handle == item_q.handle)) begin
					match_found_q <= 1'b1;
					match_idx_q   <= idx_s1;
				end
				// best entry plus the smallest due time among the rest
				if (vld_s1) begin
					if (key_lt) begin
						best_found_q <= 1'b1;
						best_q       <= rd_s1;
						best_idx_q   <= idx_s1;
						if (best_found_q) second_due_q <= best_q.due;
					end else if (rd_s1.due < second_due_q) begin
						second_due_q <= rd_s1.due;
					end
				end
			end
		end
	end

	// reschedule time: saturating add, then not earlier than now
	assign due_sum = {1'b0, best_q.due} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, best_q.period};
	assign due_sat = due_sum[TIME_W] ? TIME_MAX : due_sum[TIME_W-1:0];
	assign due_new = (due_sat < item_q.now_time) ? item_q.now_time : due_sat;
	assign best_due_or_max = best_found_q ? best_q.due : TIME_MAX;

	// execute
	always_comb begin
		mem_we       = 1'b0;
		mem_waddr    = free_idx_q;
		mem_wdata    = best_q;
		valid_set    = 1'b0;
		valid_clr    = 1'b0;
		stamp_inc    = 1'b0;
		res_d.status       = ST_OK;
		res_d.fired_handle = '0;
		res_d.next_due     = best_due_or_max;
		case (item_q.op)
			OP_ADD: begin
				if (match_found_q) begin
					res_d.status = ST_DUP;
				end else if (!free_found_q) begin
					res_d.status = ST_FULL;
				end else begin
					mem_we           = 1'b1;
					mem_waddr        = free_idx_q;
					mem_wdata.handle = item_q.handle;
					mem_wdata.period = item_q.period_ms;
					mem_wdata.due    = item_q.start_time;
					mem_wdata.stamp  = stamp_q;
					valid_set        = 1'b1;
					stamp_inc        = 1'b1;
					if (item_q.start_time < best_due_or_max) begin
						res_d.next_due = item_q.start_time;
					end
				end
			end
			OP_REMOVE: begin
				if (!match_found_q) begin
					res_d.status = ST_ABSENT;
				end else begin
					valid_clr = 1'b1;
					if (match_idx_q == best_idx_q) res_d.next_due = second_due_q;
				end
			end
			OP_REQUEST: begin
				if (!best_found_q || (item_q.now_time < best_q.due)) begin
					res_d.status = ST_NONE;
				end else begin
					mem_we             = 1'b1;
					mem_waddr          = best_idx_q;
					mem_wdata.due      = due_new;
					mem_wdata.stamp    = stamp_q;
					stamp_inc          = 1'b1;
					res_d.fired_handle = best_q.handle;
					res_d.next_due     = (due_new < second_due_q) ? due_new : second_due_q;
				end
			end
			OP_SPARE: begin
				res_d.status = ST_OK;
			end
			default: begin
				res_d.status = ST_OK;
			end
		endcase
		if (!cmd.exec) begin
			mem_we    = 1'b0;
			valid_set = 1'b0;
			valid_clr = 1'b0;
			stamp_inc = 1'b0;
		end
	end

	// valid bits, stamp counter, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			stamp_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (valid_set) valid_q[free_idx_q] <= 1'b1;
			if (valid_clr) valid_q[match_idx_q] <= 1'b0;
			if (stamp_inc) stamp_q <= stamp_q + STAMP_W'(1);
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) out_item_q <= res_d;
	end

endmodule

[rtl/periodic_event_scheduler_core.sv]
// Periodic event scheduler, top level: joins the controller and datapath
// to the input and result channels. Depends on pes_pkg, pes_if, pes_ctrl,
// pes_dpath.
//
// The block keeps a table of up to SLOTS periodic events and answers add,
// remove and request items with exactly one result item each. Each item
// passes through an accept step, one read per slot through the single
// read port of the slot memory, a step to finish the last compare and
// one to execute and write back; the next item is accepted only after
// that execute. The result sits in an output register, so the next item
// is accepted and scanned while the previous result waits to be taken;
// its execute cycle then waits until that register is free. No clearing
// pass is needed after reset; slot valid bits are flops.
module periodic_event_scheduler_core import pes_pkg::*; #(
	parameter int unsigned SLOTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	pes_in_if.sink     in_ch,
	pes_out_if.source  out_ch
);

	localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	ctl_cmd_t      cmd;
	dp_stat_t      stat;
	logic [AW-1:0] rd_addr;

	pes_ctrl #(
		.SLOTS (SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd),
		.rd_addr  (rd_addr)
	);

	pes_dpath #(
		.SLOTS (SLOTS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.stat      (stat),
		.in_item   (in_ch.item),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_item  (out_ch.item)
	);

endmodule

[dv/tb.sv]
// Self-checking testbench for periodic_event_scheduler_core: directed and random
// add/remove/request items, checked against a built-in model of the event table.
// Depends on pes_pkg, pes_if and the RTL of the scheduler.
`timescale 1ns / 100ps

module tb;
	import pes_pkg::*;

	localparam int unsigned TB_SLOTS     = 16;
	localparam int          RANDOM_ITEMS = 1070;
	localparam int          STALL_LONG   = 300;   // long receiver hold-off, cycles
	localparam int          DRAIN_CYCLES = 64;
	localparam int          MAX_REPORTS  = 100;

	logic clk;
	logic arst_n;

	pes_in_if  in_ch ();
	pes_out_if out_ch ();

	periodic_event_scheduler_core #(
		.SLOTS (TB_SLOTS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #6 clk = ~clk;

	// item streams
	in_item_t  op_queue[$];          // items still to be offered
	out_item_t expected_results[$];  // predicted results, oldest first

	int mismatch_count;
	int items_accepted;
	int results_taken;
	int send_gap;
	int recv_wait;

	// event table as the scheduler should hold it
	bit                  ev_valid  [TB_SLOTS];
	logic [HANDLE_W-1:0] ev_handle [TB_SLOTS];
	logic [PERIOD_W-1:0] ev_period [TB_SLOTS];
	logic [TIME_W-1:0]   ev_due    [TB_SLOTS];
	logic [STAMP_W-1:0]  ev_stamp  [TB_SLOTS];
	logic [STAMP_W-1:0]  stamp_next;

	// earliest due live entry, ties to the older stamp; -1 when empty
	function automatic int earliest_event();
		int best = -1;
		for (int i = 0; i < TB_SLOTS; i++) begin
			if (ev_valid[i] && (best < 0 || ev_due[i] < ev_due[best] ||
					(ev_due[i] == ev_due[best] && ev_stamp[i] < ev_stamp[best])))
				best = i;
		end
		return best;
	endfunction

	function automatic int slot_of_handle(input logic [HANDLE_W-1:0] h);
		for (int i = 0; i < TB_SLOTS; i++)
			if (ev_valid[i] && ev_handle[i] == h)
				return i;
		return -1;
	endfunction

	// apply one item to the table and return the result it should produce
	function automatic out_item_t sched_apply(input in_item_t it);
		out_item_t          res;
		int                 idx;
		logic [TIME_W:0]    sum;
		logic [TIME_W-1:0]  nd;
		res.status       = ST_OK;
		res.fired_handle = '0;
		case (it.op)
			OP_ADD: begin
				if (slot_of_handle(it.handle) >= 0) begin
					res.status = ST_DUP;
				end else begin
					idx = -1;
					for (int i = 0; i < TB_SLOTS; i++) begin
						if (!ev_valid[i]) begin
							idx = i;
							break;
						end
					end
					if (idx < 0) begin
						res.status = ST_FULL;
					end else begin
						ev_valid[idx]  = 1'b1;
						ev_handle[idx] = it.handle;
						ev_period[idx] = it.period_ms;
						ev_due[idx]    = it.start_time;
						ev_stamp[idx]  = stamp_next;
						stamp_next++;
					end
				end
			end
			OP_REMOVE: begin
				idx = slot_of_handle(it.handle);
				if (idx < 0)
					res.status = ST_ABSENT;
				else
					ev_valid[idx] = 1'b0;
			end
			OP_REQUEST: begin
				idx = earliest_event();
				if (idx < 0 || it.now_time < ev_due[idx]) begin
					res.status = ST_NONE;
				end else begin
					// reschedule, saturating at the top of the time range
					sum = {1'b0, ev_due[idx]} + {{(TIME_W+1-PERIOD_W){1'b0}}, ev_period[idx]};
					nd  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
					if (nd < it.now_time)
						nd = it.now_time;
					ev_due[idx]      = nd;
					ev_stamp[idx]    = stamp_next;
					stamp_next++;
					res.fired_handle = ev_handle[idx];
				end
			end
			default: ;  // spare opcode leaves the table alone
		endcase
		idx = earliest_event();
		res.next_due = (idx < 0) ? TIME_MAX : ev_due[idx];
		return res;
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch on result %0d: %s got %0h want %0h",
				results_taken, what, got, want);
	endtask

	function automatic in_item_t make_item(input logic [OP_W-1:0] op,
			input logic [HANDLE_W-1:0] h, input logic [PERIOD_W-1:0] p,
			input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] n);
		in_item_t it;
		it.op         = op;
		it.handle     = h;
		it.period_ms  = p;
		it.start_time = s;
		it.now_time   = n;
		return it;
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] t;
		t = {$urandom, $urandom};
		return t[TIME_W-1:0];
	endfunction

	// mostly a small pool so that duplicates, removes and a full table occur
	function automatic logic [HANDLE_W-1:0] pick_handle();
		if ($urandom_range(0, 9) == 0)
			return HANDLE_W'($urandom);
		return HANDLE_W'($urandom_range(0, 19) * 16'h0c35);
	endfunction

	// stretches without idling on either side
	function automatic bool_quiet(input int count);
		return (count / 80) % 4 == 1;
	endfunction

	// input driver: offers queued items, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.item  <= '0;
			send_gap    <= 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid) begin
				expected_results.push_back(sched_apply(in_ch.item));
				items_accepted++;
			end
			if (send_gap > 0) begin
				in_ch.valid <= 1'b0;
				send_gap    <= send_gap - 1;
			end else if (op_queue.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.item  <= op_queue.pop_front();
				send_gap    <= bool_quiet(items_accepted) ? 0 : $urandom_range(0, 7);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor: checks each result, paces ready with random stalls
	always @(posedge clk or negedge arst_n) begin
		int        wait_cycles;
		out_item_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_wait    <= 0;
		end else begin
			wait_cycles = recv_wait;
			if (out_ch.valid && out_ch.ready) begin
				results_taken++;
				if (expected_results.size() == 0) begin
					note_mismatch("unexpected result", 64'(out_ch.item), '0);
				end else begin
					want = expected_results.pop_front();
					if (out_ch.item.status !== want.status)
						note_mismatch("status", 64'(out_ch.item.status), 64'(want.status));
					if (out_ch.item.fired_handle !== want.fired_handle)
						note_mismatch("fired_handle", 64'(out_ch.item.fired_handle),
							64'(want.fired_handle));
					if (out_ch.item.next_due !== want.next_due)
						note_mismatch("next_due", 64'(out_ch.item.next_due),
							64'(want.next_due));
				end
				// long hold-off lets the block fill and back up its input
				if (results_taken == 250 || results_taken == 700)
					wait_cycles = STALL_LONG;
				else if (bool_quiet(results_taken))
					wait_cycles = 0;
				else
					wait_cycles = $urandom_range(0, 7);
			end
			if (wait_cycles > 0) begin
				out_ch.ready <= 1'b0;
				recv_wait    <= wait_cycles - 1;
			end else begin
				out_ch.ready <= 1'b1;
				recv_wait    <= 0;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		in_item_t          it;
		logic [TIME_W-1:0] sim_ms;
		int                pick;
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.item     = '0;
		out_ch.ready   = 1'b0;
		mismatch_count = 0;
		items_accepted = 0;
		results_taken  = 0;
		send_gap       = 0;
		recv_wait      = 0;
		stamp_next     = '0;
		foreach (ev_valid[i])
			ev_valid[i] = 1'b0;

		// directed: empty table, absent handle, zero period, saturation
		op_queue.push_back(make_item(OP_REQUEST, '0, '0, '0, '0));
		op_queue.push_back(make_item(OP_REMOVE, 16'h0005, '0, '0, '0));
		op_queue.push_back(make_item(OP_ADD, 16'h0000, '0, '0, '0));
		op_queue.push_back(make_item(OP_REQUEST, '0, '0, '0, '0));
		op_queue.push_back(make_item(OP_ADD, 16'hffff, '1, TIME_MAX - 1, '0));
		op_queue.push_back(make_item(OP_REMOVE, 16'h0000, '0, '0, '0));
		op_queue.push_back(make_item(OP_REQUEST, '0, '0, '0, TIME_MAX - 2));
		op_queue.push_back(make_item(OP_REQUEST, '0, '0, '0, TIME_MAX));
		op_queue.push_back(make_item(OP_REMOVE, 16'hffff, '1, '1, '1));
		op_queue.push_back(make_item(OP_SPARE, '1, '1, '1, '1));
		// fill the table with equal due times, then full and duplicate adds
		for (int i = 0; i < TB_SLOTS; i++)
			op_queue.push_back(make_item(OP_ADD, HANDLE_W'(16'h0100 + i), 32'd7,
				48'd1000, '0));
		op_queue.push_back(make_item(OP_ADD, 16'h0200, 32'd7, 48'd1000, '0));
		op_queue.push_back(make_item(OP_ADD, 16'h0100, 32'd7, 48'd1000, '0));
		op_queue.push_back(make_item(OP_REQUEST, '0, '0, '0, 48'd1000));
		op_queue.push_back(make_item(OP_REQUEST, '0, '0, '0, 48'd1000));

		// random: a time base that moves forward, with rare far jumps
		sim_ms = 48'd1000;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			it   = make_item(OP_SPARE, pick_handle(), $urandom, rand_time(), rand_time());
			if (pick < 40) begin
				it.op = OP_ADD;
				case ($urandom_range(0, 9))
					0: it.period_ms = '0;
					1: ;  // full-range period
					default: it.period_ms = $urandom_range(1, 60);
				endcase
				case ($urandom_range(0, 19))
					0: ;  // full-range start
					1: it.start_time = TIME_MAX - $urandom_range(0, 100);
					default: it.start_time = sim_ms + $urandom_range(0, 150);
				endcase
			end else if (pick < 60) begin
				it.op = OP_REMOVE;
			end else if (pick < 98) begin
				it.op = OP_REQUEST;
				case ($urandom_range(0, 49))
					0: it.now_time = TIME_MAX;
					1: ;  // full-range time
					default: begin
						sim_ms      = sim_ms + $urandom_range(0, 30);
						it.now_time = sim_ms;
					end
				endcase
			end
			op_queue.push_back(it);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (op_queue.size() != 0 || in_ch.valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2500000;
		$display("FAIL");
		$finish;
	end

endmodule
